// ===== sv/mew_pkg.sv =====
// Shared types, widths and codes for the midpoint ellipse outline walker.
// Used by mew_dpath, mew_ctrl and the top level; depends on nothing.
`timescale 1ns / 1ps

package mew_pkg;

    // Coordinate width and derived datapath widths
    localparam int COORD_BITS = 12;
    localparam int OFS_W  = COORD_BITS + 2;       // signed offsets
    localparam int SQR_W  = 2 * COORD_BITS;       // squared radii
    localparam int MUL_W  = 2 * COORD_BITS + 2;   // multiplier operands
    localparam int PROD_W = 2 * MUL_W;            // multiplier products
    localparam int SLP_W  = 3 * COORD_BITS + 2;   // signed slopes
    localparam int DEC_W  = PROD_W;               // signed decision, scaled by 4

    // Configuration register indexes
    localparam logic [1:0] CFG_START_X  = 2'd0;
    localparam logic [1:0] CFG_START_Y  = 2'd1;
    localparam logic [1:0] CFG_FINISH_X = 2'd2;
    localparam logic [1:0] CFG_FINISH_Y = 2'd3;

    // Walk phases
    typedef logic [1:0] t_phase;
    localparam t_phase PH_IDLE = 2'd0;
    localparam t_phase PH_SCAN = 2'd1;
    localparam t_phase PH_R1   = 2'd2;
    localparam t_phase PH_R2   = 2'd3;

    // Datapath operations
    typedef logic [3:0] t_op;
    localparam t_op OP_NONE   = 4'd0;
    localparam t_op OP_SETUP  = 4'd1;
    localparam t_op OP_SQ0    = 4'd2;
    localparam t_op OP_SQ1    = 4'd3;
    localparam t_op OP_SQ2    = 4'd4;
    localparam t_op OP_EMIT   = 4'd5;
    localparam t_op OP_ADV    = 4'd6;
    localparam t_op OP_R2A    = 4'd7;
    localparam t_op OP_R2B    = 4'd8;
    localparam t_op OP_R2C    = 4'd9;
    localparam t_op OP_NEXTQ  = 4'd10;
    localparam t_op OP_KILL   = 4'd11;
    localparam t_op OP_FINISH = 4'd12;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        t_phase phase;
        logic   r1_hold;    // region 1 still holds a point
        logic   r2_hold;    // region 2 still holds a point
        logic   last_quad;
    } t_dp_stat;

endpackage

// ===== sv/mew_dpath.sv =====
// Datapath of the ellipse walker: corner registers, walk state, two multipliers
// and the result word registers. Depends on mew_pkg; driven by mew_ctrl.
`timescale 1ns / 1ps

module mew_dpath
    import mew_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [1:0]            i_cfg_index,
    input  logic [COORD_BITS-1:0] i_cfg_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output logic [COORD_BITS-1:0] o_out_x,
    output logic [COORD_BITS-1:0] o_out_y,
    output logic                  o_is_last,
    output logic                  o_valid_res
);

    logic [COORD_BITS-1:0] r_sx, r_sy, r_fx, r_fy;

    t_phase                   r_phase, n_phase;
    logic [1:0]               r_quad, n_quad;
    logic                     r_tall, n_tall;
    logic                     r_odd_x, n_odd_x, r_odd_y, n_odd_y;
    logic [COORD_BITS-1:0]    r_cx, n_cx, r_cy, n_cy;
    logic [COORD_BITS-1:0]    r_rx, n_rx, r_ry, n_ry;
    logic signed [OFS_W-1:0]  r_ox, n_ox, r_oy, n_oy;
    logic signed [SLP_W-1:0]  r_slx, n_slx, r_sly, n_sly;
    logic signed [DEC_W-1:0]  r_dec, n_dec;
    logic [SQR_W-1:0]         r_rx2, n_rx2, r_ry2, n_ry2;
    logic [PROD_W-1:0]        r_k, n_k, r_pq, n_pq;
    logic [PROD_W-1:0]        r_p0, r_p1;
    logic [COORD_BITS-1:0]    r_px, n_px, r_py, n_py;
    logic                     r_emit_ok, n_emit_ok;
    logic [COORD_BITS-1:0]    r_out_x, r_out_y;
    logic                     r_is_last, r_valid_res;

    logic [MUL_W-1:0] m0a, m0b, m1a, m1b;

    // Setup terms
    logic [COORD_BITS-1:0] adx, ady;
    logic [COORD_BITS:0]   sum_x, sum_y;
    logic [COORD_BITS-1:0] hrx, hry;

    // Advance terms
    logic signed [SLP_W-1:0] two_rx2, two_ry2;
    logic signed [SLP_W-1:0] slx_inc, slx_dec, sly_inc, sly_dec;
    logic signed [DEC_W-1:0] four_rx2, four_ry2;
    logic                    dec_neg, dec_le0;

    // Square operands for region 2 entry
    logic signed [OFS_W:0]   sq_a, sq_b;
    logic [OFS_W:0]          abs_a, abs_b;

    // Point terms
    logic                  pos_x, pos_y;
    logic [COORD_BITS-1:0] qcx, qcy;

    // Hold the corner registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= '0;
            r_sy <= '0;
            r_fx <= '0;
            r_fy <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START_X:  r_sx <= i_cfg_data;
                CFG_START_Y:  r_sy <= i_cfg_data;
                CFG_FINISH_X: r_fx <= i_cfg_data;
                CFG_FINISH_Y: r_fy <= i_cfg_data;
            endcase
        end
    end

    assign adx   = (r_sx > r_fx) ? r_sx - r_fx : r_fx - r_sx;
    assign ady   = (r_sy > r_fy) ? r_sy - r_fy : r_fy - r_sy;
    assign sum_x = {1'b0, r_sx} + {1'b0, r_fx};
    assign sum_y = {1'b0, r_sy} + {1'b0, r_fy};
    assign hrx   = adx >> 1;
    assign hry   = ady >> 1;

    assign two_rx2  = SLP_W'({1'b0, r_rx2, 1'b0});
    assign two_ry2  = SLP_W'({1'b0, r_ry2, 1'b0});
    assign four_rx2 = DEC_W'({r_rx2, 2'b00});
    assign four_ry2 = DEC_W'({r_ry2, 2'b00});
    assign slx_inc  = r_slx + two_ry2;
    assign slx_dec  = r_slx - two_ry2;
    assign sly_inc  = r_sly + two_rx2;
    assign sly_dec  = r_sly - two_rx2;
    assign dec_neg  = r_dec[DEC_W-1];
    assign dec_le0  = dec_neg || (r_dec == '0);

    // Region 2 entry squares: tall uses (2x+1, y-1), wide uses (2y+1, x-1)
    assign sq_a  = r_tall ? {r_ox, 1'b1} : {r_oy, 1'b1};
    assign sq_b  = r_tall ? (OFS_W+1)'(r_oy) - 2'sd1 : (OFS_W+1)'(r_ox) - 2'sd1;
    assign abs_a = sq_a[OFS_W] ? (OFS_W+1)'(-sq_a) : (OFS_W+1)'(sq_a);
    assign abs_b = sq_b[OFS_W] ? (OFS_W+1)'(-sq_b) : (OFS_W+1)'(sq_b);

    // Select multiplier operands
    always_comb begin
        m0a = MUL_W'(r_rx);
        m0b = MUL_W'(r_rx);
        m1a = MUL_W'(r_ry);
        m1b = MUL_W'(r_ry);
        unique case (i_cmd.op)
            OP_SQ1: begin
                m0a = r_p0[MUL_W-1:0];
                m0b = r_p1[MUL_W-1:0];
                m1a = r_tall ? r_p0[MUL_W-1:0] : r_p1[MUL_W-1:0];
                m1b = r_tall ? MUL_W'(r_ry) : MUL_W'(r_rx);
            end
            OP_R2A: begin
                m0a = MUL_W'(abs_a);
                m0b = MUL_W'(abs_a);
                m1a = MUL_W'(abs_b);
                m1b = MUL_W'(abs_b);
            end
            OP_R2B: begin
                m0a = r_tall ? MUL_W'(r_ry2) : MUL_W'(r_rx2);
                m0b = r_p0[MUL_W-1:0];
                m1a = r_tall ? MUL_W'(r_rx2) : MUL_W'(r_ry2);
                m1b = r_p1[MUL_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // Register the products
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_SQ0 || i_cmd.op == OP_SQ1 ||
            i_cmd.op == OP_R2A || i_cmd.op == OP_R2B) begin
            r_p0 <= m0a * m0b;
            r_p1 <= m1a * m1b;
        end
    end

    // Form the current point
    assign pos_x = (r_quad == 2'd0) || (r_quad == 2'd3);
    assign pos_y = (r_quad == 2'd0) || (r_quad == 2'd1);
    assign qcx   = r_cx + COORD_BITS'(pos_x & r_odd_x);
    assign qcy   = r_cy + COORD_BITS'(pos_y & r_odd_y);

    // Next state of the walk
    always_comb begin
        n_phase   = r_phase;
        n_quad    = r_quad;
        n_tall    = r_tall;
        n_odd_x   = r_odd_x;
        n_odd_y   = r_odd_y;
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_rx      = r_rx;
        n_ry      = r_ry;
        n_ox      = r_ox;
        n_oy      = r_oy;
        n_slx     = r_slx;
        n_sly     = r_sly;
        n_dec     = r_dec;
        n_rx2     = r_rx2;
        n_ry2     = r_ry2;
        n_k       = r_k;
        n_pq      = r_pq;
        n_px      = r_px;
        n_py      = r_py;
        n_emit_ok = r_emit_ok;
        unique case (i_cmd.op)
            OP_SETUP: begin
                n_ox   = '0;
                n_oy   = '0;
                n_slx  = '0;
                n_sly  = '0;
                n_dec  = '0;
                n_quad = '0;
                if (adx < COORD_BITS'(2) || ady < COORD_BITS'(2)) begin
                    n_cx    = (r_sx < r_fx) ? r_sx : r_fx;
                    n_cy    = (r_sy < r_fy) ? r_sy : r_fy;
                    n_rx    = adx;
                    n_ry    = ady;
                    n_odd_x = 1'b0;
                    n_odd_y = 1'b0;
                    n_tall  = 1'b0;
                    n_phase = PH_SCAN;
                end else begin
                    n_cx    = sum_x[COORD_BITS:1];
                    n_cy    = sum_y[COORD_BITS:1];
                    n_odd_x = sum_x[0];
                    n_odd_y = sum_y[0];
                    n_rx    = hrx;
                    n_ry    = hry;
                    n_tall  = hrx < hry;
                    n_phase = PH_R1;
                end
            end
            OP_SQ1: begin
                n_rx2 = r_p0[SQR_W-1:0];
                n_ry2 = r_p1[SQR_W-1:0];
            end
            OP_SQ2, OP_NEXTQ: begin
                // Start a quadrant; the radius products do not change per quadrant
                if (i_cmd.op == OP_SQ2) begin
                    n_k  = r_p0;
                    n_pq = r_p1;
                end else begin
                    n_quad = r_quad + 2'd1;
                end
                if (r_tall) begin
                    n_ox  = '0;
                    n_oy  = OFS_W'(r_ry);
                    n_slx = '0;
                    n_sly = SLP_W'({(i_cmd.op == OP_SQ2) ? r_p1 : r_pq, 1'b0});
                    n_dec = four_ry2 - (((i_cmd.op == OP_SQ2) ? r_p1 : r_pq) << 2)
                          + DEC_W'(r_rx2);
                end else begin
                    n_ox  = OFS_W'(r_rx);
                    n_oy  = '0;
                    n_slx = SLP_W'({(i_cmd.op == OP_SQ2) ? r_p1 : r_pq, 1'b0});
                    n_sly = '0;
                    n_dec = four_rx2 - (((i_cmd.op == OP_SQ2) ? r_p1 : r_pq) << 2)
                          + DEC_W'(r_ry2);
                end
                n_phase = PH_R1;
            end
            OP_R2C: begin
                n_dec   = r_p0 + (r_p1 << 2) - (r_k << 2);
                n_phase = PH_R2;
            end
            OP_KILL: begin
                n_phase = PH_IDLE;
            end
            OP_EMIT: begin
                n_emit_ok = (r_phase != PH_IDLE);
                if (r_phase == PH_SCAN) begin
                    n_px = r_cx + r_ox[COORD_BITS-1:0];
                    n_py = r_cy + r_oy[COORD_BITS-1:0];
                end else begin
                    n_px = pos_x ? qcx + r_ox[COORD_BITS-1:0] : qcx - r_ox[COORD_BITS-1:0];
                    n_py = pos_y ? qcy + r_oy[COORD_BITS-1:0] : qcy - r_oy[COORD_BITS-1:0];
                end
            end
            OP_ADV: begin
                unique case (r_phase)
                    PH_SCAN: begin
                        // Step along the row, wrap to the next row
                        if (r_ox + 2'sd1 > OFS_W'(r_rx)) begin
                            n_ox = '0;
                            n_oy = r_oy + 2'sd1;
                            if (r_oy + 2'sd1 > OFS_W'(r_ry)) begin
                                n_phase = PH_IDLE;
                            end
                        end else begin
                            n_ox = r_ox + 2'sd1;
                        end
                    end
                    PH_R1: begin
                        if (r_tall) begin
                            n_ox  = r_ox + 2'sd1;
                            n_slx = slx_inc;
                            if (!dec_neg) begin
                                n_oy  = r_oy - 2'sd1;
                                n_sly = sly_dec;
                                n_dec = r_dec - (DEC_W'(sly_dec) <<< 2)
                                      + (DEC_W'(slx_inc) <<< 2) + four_ry2;
                            end else begin
                                n_dec = r_dec + (DEC_W'(slx_inc) <<< 2) + four_ry2;
                            end
                        end else begin
                            n_oy  = r_oy + 2'sd1;
                            n_sly = sly_inc;
                            if (!dec_neg) begin
                                n_ox  = r_ox - 2'sd1;
                                n_slx = slx_dec;
                                n_dec = r_dec - (DEC_W'(slx_dec) <<< 2)
                                      + (DEC_W'(sly_inc) <<< 2) + four_rx2;
                            end else begin
                                n_dec = r_dec + (DEC_W'(sly_inc) <<< 2) + four_rx2;
                            end
                        end
                    end
                    PH_R2: begin
                        if (r_tall) begin
                            n_oy  = r_oy - 2'sd1;
                            n_sly = sly_dec;
                            if (dec_le0) begin
                                n_ox  = r_ox + 2'sd1;
                                n_slx = slx_inc;
                                n_dec = r_dec + (DEC_W'(slx_inc) <<< 2)
                                      + four_rx2 - (DEC_W'(sly_dec) <<< 2);
                            end else begin
                                n_dec = r_dec + four_rx2 - (DEC_W'(sly_dec) <<< 2);
                            end
                        end else begin
                            n_ox  = r_ox - 2'sd1;
                            n_slx = slx_dec;
                            if (dec_le0) begin
                                n_oy  = r_oy + 2'sd1;
                                n_sly = sly_inc;
                                n_dec = r_dec + (DEC_W'(sly_inc) <<< 2)
                                      + four_ry2 - (DEC_W'(slx_dec) <<< 2);
                            end else begin
                                n_dec = r_dec + four_ry2 - (DEC_W'(slx_dec) <<< 2);
                            end
                        end
                    end
                    PH_IDLE: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // Control state of the walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_quad  <= '0;
            r_tall  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_quad  <= n_quad;
            r_tall  <= n_tall;
        end
    end

    // Payload state of the walk
    always_ff @(posedge i_clk) begin
        r_odd_x   <= n_odd_x;
        r_odd_y   <= n_odd_y;
        r_cx      <= n_cx;
        r_cy      <= n_cy;
        r_rx      <= n_rx;
        r_ry      <= n_ry;
        r_ox      <= n_ox;
        r_oy      <= n_oy;
        r_slx     <= n_slx;
        r_sly     <= n_sly;
        r_dec     <= n_dec;
        r_rx2     <= n_rx2;
        r_ry2     <= n_ry2;
        r_k       <= n_k;
        r_pq      <= n_pq;
        r_px      <= n_px;
        r_py      <= n_py;
        r_emit_ok <= n_emit_ok;
    end

    // Load the result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_FINISH) begin
            r_out_x     <= r_emit_ok ? r_px : '0;
            r_out_y     <= r_emit_ok ? r_py : '0;
            r_is_last   <= r_emit_ok && (r_phase == PH_IDLE);
            r_valid_res <= r_emit_ok;
        end
    end

    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_is_last   = r_is_last;
    assign o_valid_res = r_valid_res;

    assign o_stat.phase     = r_phase;
    assign o_stat.r1_hold   = r_tall ? (r_slx < r_sly) : (r_sly < r_slx);
    assign o_stat.r2_hold   = r_tall ? !r_oy[OFS_W-1] : !r_ox[OFS_W-1];
    assign o_stat.last_quad = (r_quad == 2'd3);

endmodule

// ===== sv/mew_ctrl.sv =====
// Sequencer of the ellipse walker: steps setup, emit, advance and region/quadrant
// changes, and owns the handshakes. Depends on mew_pkg; drives mew_dpath.
`timescale 1ns / 1ps

module mew_ctrl
    import mew_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_restart,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SU2    = 4'd1;
    localparam logic [3:0] S_SU3    = 4'd2;
    localparam logic [3:0] S_SU4    = 4'd3;
    localparam logic [3:0] S_SETTLE = 4'd4;
    localparam logic [3:0] S_EMIT   = 4'd5;
    localparam logic [3:0] S_ADV    = 4'd6;
    localparam logic [3:0] S_R2A    = 4'd7;
    localparam logic [3:0] S_R2B    = 4'd8;
    localparam logic [3:0] S_R2C    = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;

    logic [3:0] r_state, n_state;
    logic       r_post, n_post;
    logic       r_out_valid, n_out_valid;
    logic       slot_free;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // Sequence the datapath
    always_comb begin
        n_state     = r_state;
        n_post      = r_post;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op    = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_restart) begin
                        o_cmd.op = OP_SETUP;
                        n_state  = S_SU2;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_SU2: begin
                if (i_stat.phase == PH_SCAN) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.op = OP_SQ0;
                    n_state  = S_SU3;
                end
            end
            S_SU3: begin
                o_cmd.op = OP_SQ1;
                n_state  = S_SU4;
            end
            S_SU4: begin
                o_cmd.op = OP_SQ2;
                n_post   = 1'b0;
                n_state  = S_SETTLE;
            end
            S_SETTLE: begin
                // Move on until the state holds a point or the run ends
                if (i_stat.phase == PH_R1 && !i_stat.r1_hold) begin
                    n_state = S_R2A;
                end else if (i_stat.phase == PH_R2 && !i_stat.r2_hold) begin
                    o_cmd.op = i_stat.last_quad ? OP_KILL : OP_NEXTQ;
                end else begin
                    n_state = r_post ? S_FIN : S_EMIT;
                end
            end
            S_R2A: begin
                o_cmd.op = OP_R2A;
                n_state  = S_R2B;
            end
            S_R2B: begin
                o_cmd.op = OP_R2B;
                n_state  = S_R2C;
            end
            S_R2C: begin
                o_cmd.op = OP_R2C;
                n_state  = S_SETTLE;
            end
            S_EMIT: begin
                o_cmd.op = OP_EMIT;
                n_state  = S_ADV;
            end
            S_ADV: begin
                o_cmd.op = OP_ADV;
                n_post   = 1'b1;
                n_state  = S_SETTLE;
            end
            S_FIN: begin
                if (slot_free) begin
                    o_cmd.op    = OP_FINISH;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_post      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_post      <= n_post;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_restart_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_restart) |=> (r_state == S_SU2))
        else $error("restart did not enter setup");

    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && slot_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished word not loaded");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("result word dropped while stalled");

    a_r2_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_R2A) |=> (r_state == S_R2B) ##1 (r_state == S_R2C))
        else $error("region 2 setup sequence broken");

endmodule

// ===== sv/midpoint_ellipse_outline_walker_top.sv =====
// Top level of the midpoint ellipse outline walker.
// Depends on mew_pkg, mew_dpath and mew_ctrl.
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------
//  in      | i_in_valid/o_in_ready  | i_restart
//  out     | o_out_valid/i_out_ready| o_out_x, o_out_y, o_is_last, o_valid_res
//  cfg     | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// Sequence: an advance word runs emit, advance, settle and load to its result, plus
// each region change in three steps (R2A, R2B, R2C), each quadrant change and the
// end of the outline where met; the next word is taken the cycle after the load.
// A restart first runs setup through the shared pair of multipliers (SQ0, SQ1,
// SQ2), or only the box check when the box falls back to the row scan.
// Reset: synchronous, active low; the run starts exhausted. No clearing pass.
// Stalls: one result word is held in the output register; the next input word is
// taken while it waits, and its result waits for the register to empty.
`timescale 1ns / 1ps

module midpoint_ellipse_outline_walker_top
    import mew_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_restart,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [COORD_BITS-1:0] o_out_x,
    output logic [COORD_BITS-1:0] o_out_y,
    output logic                  o_is_last,
    output logic                  o_valid_res,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [COORD_BITS-1:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    mew_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mew_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_is_last   (o_is_last),
        .o_valid_res (o_valid_res)
    );

endmodule

// ===== dv/tb_midpoint_ellipse_outline_walker_top.sv =====
// Self-checking testbench for the midpoint ellipse outline walker top level.
// Depends on mew_pkg and the RTL; a built-in outline predictor checks every word.
`timescale 1ns / 1ps

module tb_midpoint_ellipse_outline_walker_top;
    import mew_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 64;

    typedef struct {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  last;
        logic                  vres;
    } t_point;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_restart;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [COORD_BITS-1:0] o_out_x;
    logic [COORD_BITS-1:0] o_out_y;
    logic                  o_is_last;
    logic                  o_valid_res;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [1:0]            i_cfg_index;
    logic [COORD_BITS-1:0] i_cfg_data;

    midpoint_ellipse_outline_walker_top DUT (.*);

    // Clock generation
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic   pending_restart[$];
    t_point exp_points[$];
    int     fail_count = 0;
    int     cycle_count = 0;
    bit     no_idle = 0;
    bit     hold_req = 0;
    bit     hold_done = 0;

    // Predictor state: corners plus walker registers
    logic [COORD_BITS-1:0] box_sx, box_sy, box_fx, box_fy;
    t_phase  wk_phase;
    int      wk_quad;
    int      wk_ox, wk_oy;
    longint  wk_slx, wk_sly, wk_dec;
    int      wk_cx, wk_cy, wk_rx, wk_ry, wk_oddx, wk_oddy;
    bit      wk_tall;

    function automatic void quad_init();
        longint rx2, ry2;
        rx2 = longint'(wk_rx) * wk_rx;
        ry2 = longint'(wk_ry) * wk_ry;
        if (wk_tall) begin
            wk_ox = 0;
            wk_oy = wk_ry;
            wk_slx = 0;
            wk_sly = 2 * rx2 * wk_ry;
            wk_dec = 4 * ry2 - 4 * rx2 * wk_ry + rx2;
        end else begin
            wk_ox = wk_rx;
            wk_oy = 0;
            wk_slx = 2 * ry2 * wk_rx;
            wk_sly = 0;
            wk_dec = 4 * rx2 - 4 * ry2 * wk_rx + ry2;
        end
        wk_phase = PH_R1;
    endfunction

    function automatic void region2_init();
        longint rx2, ry2, a, b;
        rx2 = longint'(wk_rx) * wk_rx;
        ry2 = longint'(wk_ry) * wk_ry;
        if (wk_tall) begin
            a = 2 * longint'(wk_ox) + 1;
            b = longint'(wk_oy) - 1;
            wk_dec = ry2 * a * a + 4 * rx2 * b * b - 4 * rx2 * ry2;
        end else begin
            a = 2 * longint'(wk_oy) + 1;
            b = longint'(wk_ox) - 1;
            wk_dec = rx2 * a * a + 4 * ry2 * b * b - 4 * rx2 * ry2;
        end
        wk_phase = PH_R2;
    endfunction

    // Walk forward until a point is held or the outline is done
    function automatic void settle_walk();
        for (int g = 0; g < 16; g++) begin
            if (wk_phase == PH_R1) begin
                if (wk_tall ? (wk_slx < wk_sly) : (wk_sly < wk_slx)) return;
                region2_init();
            end else if (wk_phase == PH_R2) begin
                if (wk_tall ? (wk_oy >= 0) : (wk_ox >= 0)) return;
                if (wk_quad >= 3) begin
                    wk_phase = PH_IDLE;
                    return;
                end
                wk_quad++;
                quad_init();
            end else begin
                return;
            end
        end
        wk_phase = PH_IDLE;
    endfunction

    function automatic void step_walk();
        longint trx2, try2;
        bit le0;
        trx2 = 2 * longint'(wk_rx) * wk_rx;
        try2 = 2 * longint'(wk_ry) * wk_ry;
        if (wk_phase == PH_SCAN) begin
            wk_ox++;
            if (wk_ox > wk_rx) begin
                wk_ox = 0;
                wk_oy++;
                if (wk_oy > wk_ry) wk_phase = PH_IDLE;
            end
            return;
        end
        if (wk_phase == PH_R1) begin
            if (wk_tall) begin
                wk_ox++;
                wk_slx += try2;
                if (wk_dec >= 0) begin
                    wk_oy--;
                    wk_sly -= trx2;
                    wk_dec -= wk_sly * 4;
                end
                wk_dec += wk_slx * 4 + 2 * try2;
            end else begin
                wk_oy++;
                wk_sly += trx2;
                if (wk_dec >= 0) begin
                    wk_ox--;
                    wk_slx -= try2;
                    wk_dec -= wk_slx * 4;
                end
                wk_dec += wk_sly * 4 + 2 * trx2;
            end
        end else if (wk_phase == PH_R2) begin
            le0 = (wk_dec <= 0);
            if (wk_tall) begin
                wk_oy--;
                wk_sly -= trx2;
                if (le0) begin
                    wk_ox++;
                    wk_slx += try2;
                    wk_dec += wk_slx * 4;
                end
                wk_dec += 2 * trx2 - wk_sly * 4;
            end else begin
                wk_ox--;
                wk_slx -= try2;
                if (le0) begin
                    wk_oy++;
                    wk_sly += trx2;
                    wk_dec += wk_sly * 4;
                end
                wk_dec += 2 * try2 - wk_slx * 4;
            end
        end else begin
            return;
        end
        settle_walk();
    endfunction

    function automatic void start_walk();
        int sx, sy, fx, fy, adx, ady;
        sx = box_sx;
        sy = box_sy;
        fx = box_fx;
        fy = box_fy;
        adx = sx > fx ? sx - fx : fx - sx;
        ady = sy > fy ? sy - fy : fy - sy;
        wk_ox = 0;
        wk_oy = 0;
        wk_slx = 0;
        wk_sly = 0;
        wk_dec = 0;
        wk_quad = 0;
        if (adx < 2 || ady < 2) begin
            wk_cx = sx < fx ? sx : fx;
            wk_cy = sy < fy ? sy : fy;
            wk_rx = adx;
            wk_ry = ady;
            wk_oddx = 0;
            wk_oddy = 0;
            wk_tall = 0;
            wk_phase = PH_SCAN;
            return;
        end
        wk_cx = (sx + fx) >> 1;
        wk_cy = (sy + fy) >> 1;
        wk_oddx = (sx + fx) & 1;
        wk_oddy = (sy + fy) & 1;
        wk_rx = adx >> 1;
        wk_ry = ady >> 1;
        wk_tall = wk_rx < wk_ry;
        quad_init();
        settle_walk();
    endfunction

    // Expected point for one accepted request word
    function automatic t_point next_point(logic restart);
        t_point p;
        int px, py, cx, cy;
        bit posx, posy;
        if (restart) start_walk();
        if (wk_phase == PH_IDLE) begin
            p = '{x: '0, y: '0, last: 1'b0, vres: 1'b0};
            return p;
        end
        if (wk_phase == PH_SCAN) begin
            px = wk_cx + wk_ox;
            py = wk_cy + wk_oy;
        end else begin
            posx = (wk_quad == 0 || wk_quad == 3);
            posy = (wk_quad < 2);
            cx = wk_cx + (posx ? wk_oddx : 0);
            cy = wk_cy + (posy ? wk_oddy : 0);
            px = posx ? cx + wk_ox : cx - wk_ox;
            py = posy ? cy + wk_oy : cy - wk_oy;
        end
        step_walk();
        p.x = px[COORD_BITS-1:0];
        p.y = py[COORD_BITS-1:0];
        p.last = (wk_phase == PH_IDLE);
        p.vres = 1'b1;
        return p;
    endfunction

    // Request driver: predict on acceptance, then offer the next word or idle
    int send_gap = 0;
    always @(posedge i_clk) begin
        logic nxt_valid;
        logic nxt_restart;
        nxt_valid = i_in_valid;
        nxt_restart = i_restart;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                exp_points = {exp_points, next_point(i_restart)};
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_restart.size() > 0) begin
                    if (!no_idle && $urandom_range(0, 9) == 0) begin
                        send_gap = $urandom_range(0, 4);
                    end else begin
                        nxt_valid = 1'b1;
                        nxt_restart = pending_restart.pop_front();
                    end
                end
            end
        end
        i_in_valid <= nxt_valid;
        i_restart <= nxt_restart;
    end

    // Result receiver: random stall bursts plus one long hold-off
    int recv_gap = 0;
    int hold_cnt = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            if (hold_cnt == 0) begin
                hold_cnt = 300;
                i_out_ready <= 1'b0;
            end else if (hold_cnt == 1) begin
                hold_cnt = 0;
                recv_gap = 0;
                hold_done = 1;
                i_out_ready <= 1'b1;
            end else begin
                hold_cnt--;
            end
        end else if (recv_gap > 0) begin
            recv_gap--;
            i_out_ready <= (recv_gap == 0);
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            recv_gap = $urandom_range(1, 5);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Check each delivered word against the oldest expected point
    always @(posedge i_clk) begin
        t_point e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_points.size() == 0) begin
                $display("%0t: unexpected word x=%0d y=%0d last=%0b valid=%0b", $time,
                         o_out_x, o_out_y, o_is_last, o_valid_res);
                fail_count++;
            end else begin
                e = exp_points.pop_front();
                if (o_out_x !== e.x) begin
                    $display("%0t: out_x expected %0d actual %0d", $time, e.x, o_out_x);
                    fail_count++;
                end
                if (o_out_y !== e.y) begin
                    $display("%0t: out_y expected %0d actual %0d", $time, e.y, o_out_y);
                    fail_count++;
                end
                if (o_is_last !== e.last) begin
                    $display("%0t: is_last expected %0b actual %0b", $time, e.last, o_is_last);
                    fail_count++;
                end
                if (o_valid_res !== e.vres) begin
                    $display("%0t: valid_res expected %0b actual %0b", $time, e.vres,
                             o_valid_res);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [COORD_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_START_X:  box_sx = data;
            CFG_START_Y:  box_sy = data;
            CFG_FINISH_X: box_fx = data;
            default:      box_fy = data;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_box(int sx, int sy, int fx, int fy);
        write_reg(CFG_START_X, COORD_BITS'(sx));
        write_reg(CFG_START_Y, COORD_BITS'(sy));
        write_reg(CFG_FINISH_X, COORD_BITS'(fx));
        write_reg(CFG_FINISH_Y, COORD_BITS'(fy));
    endtask

    // Hold until every queued word is sent and answered, then let the block settle
    task automatic drain();
        while (pending_restart.size() > 0 || i_in_valid || exp_points.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Queue restart-led walks over the current box; return words queued
    function automatic int queue_walks(int walks, int span);
        int n, cnt;
        cnt = 0;
        for (int w = 0; w < walks; w++) begin
            pending_restart = {pending_restart, 1'b1};
            n = $urandom_range(0, span);
            for (int k = 0; k < n; k++) begin
                // occasional stray restart breaks the walk
                pending_restart = {pending_restart, logic'($urandom_range(0, 24) == 0)};
            end
            cnt += n + 1;
        end
        return cnt;
    endfunction

    int total_items = 0;
    int rx, ry, bx, by, span;

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_restart = 1'b0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        box_sx = '0;
        box_sy = '0;
        box_fx = '0;
        box_fy = '0;
        wk_phase = PH_IDLE;
        wk_quad = 0;
        wk_ox = 0;
        wk_oy = 0;
        wk_slx = 0;
        wk_sly = 0;
        wk_dec = 0;
        wk_cx = 0;
        wk_cy = 0;
        wk_rx = 0;
        wk_ry = 0;
        wk_oddx = 0;
        wk_oddy = 0;
        wk_tall = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Exhausted after reset, then the single-point box at the origin
        pending_restart = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
        drain();
        // Full-range box, both corner orders: walk the start of the outline
        set_box(0, 0, 4095, 4095);
        pending_restart = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
        drain();
        set_box(4095, 4095, 0, 4094);
        total_items += queue_walks(1, 6) + 10;
        drain();
        // Thin boxes fall back to the row scan; odd sums shift the centre
        set_box(10, 7, 11, 9);
        pending_restart = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
        drain();
        set_box(3, 20, 8, 11);
        total_items += queue_walks(1, 40) + 12;
        drain();

        // Random boxes, mostly small so walks reach the end of the outline
        while (total_items < 1050) begin
            rx = $urandom_range(0, 9) == 0 ? $urandom_range(0, 4095) : $urandom_range(0, 24);
            ry = $urandom_range(0, 9) == 0 ? $urandom_range(0, 4095) : $urandom_range(0, 24);
            bx = $urandom_range(0, 4095 - rx);
            by = $urandom_range(0, 4095 - ry);
            if ($urandom_range(0, 1)) begin
                set_box(bx, by, bx + rx, by + ry);
            end else begin
                set_box(bx + rx, by + ry, bx, by);
            end
            span = (rx < 2 || ry < 2) ? (rx + 1) * (ry + 1) + 3 : 2 * (rx + ry) + 12;
            if (span > 80) span = 80;
            if (total_items > 500 && !hold_done) hold_req = 1;
            if (total_items > 900) no_idle = 1;
            total_items += queue_walks($urandom_range(1, 3), span);
            drain();
        end

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== midpoint_ellipse_outline_walker_top.f =====
sv/mew_pkg.sv
sv/mew_dpath.sv
sv/mew_ctrl.sv
sv/midpoint_ellipse_outline_walker_top.sv
dv/tb_midpoint_ellipse_outline_walker_top.sv
